// ===== hw/rtl/rgbh_pkg.sv =====
// Shared types and constants for the RGB histogram block.
package rgbh_pkg;

   // Widths fixed by the transaction fields
   localparam int LEVEL_W = 8;
   localparam int MODE_W  = 2;
   localparam int FIELD_W = 32;

   // Request mode codes
   localparam logic [MODE_W-1:0] MODE_COUNT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Reset value of the level limit register
   localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 8'd255;

   // Operation carried out by one channel lane
   typedef enum logic [1:0] {
      OP_NONE,
      OP_COUNT,
      OP_READ,
      OP_CLEAR
   } lane_op_type;

   // Control from the sequencer to each lane
   typedef struct packed {
      logic        load;    // capture request and read the bin
      logic        update;  // write back and release the result
      logic        clear;   // clearing sweep after reset
      lane_op_type op;
   } lane_ctrl_type;

   // Flags from each lane to the merge stage
   typedef struct packed {
      logic rejected;
      logic saturated;
   } lane_stat_type;

endpackage

// ===== hw/rtl/rgb_histogram.sv =====
// Top level of the three-channel image histogram with saturating bins.
//
//  channel   direction  handshake          payload
//  req_      in         req_valid/stall    mode, red/green/blue level, bin_index
//  rsp_      out        rsp_valid/stall    red/green/blue count, rejected, saturated
//  csr_      in         csr_valid/ready    data (level limit)
//
// Each transaction first reads the addressed bin of every lane, then writes
// it back and loads the response register; the bin memory's single
// read-modify-write sets this.
// After reset a clearing sweep zeroes the bins, with req_stall high.
// csr writes are taken at any time.
// A stalled response holds the write-back until the response register frees;
// a waiting response does not block the next request.
module rgb_histogram #(
   parameter int LEVELS     = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [rgbh_pkg::MODE_W-1:0]   req_mode,
   input  logic [rgbh_pkg::LEVEL_W-1:0]  req_red_level,
   input  logic [rgbh_pkg::LEVEL_W-1:0]  req_green_level,
   input  logic [rgbh_pkg::LEVEL_W-1:0]  req_blue_level,
   input  logic [rgbh_pkg::LEVEL_W-1:0]  req_bin_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rgbh_pkg::FIELD_W-1:0]  rsp_red_count,
   output logic [rgbh_pkg::FIELD_W-1:0]  rsp_green_count,
   output logic [rgbh_pkg::FIELD_W-1:0]  rsp_blue_count,
   output logic                          rsp_level_rejected,
   output logic                          rsp_saturated,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rgbh_pkg::LEVEL_W-1:0]  csr_data
);
   import rgbh_pkg::*;

   localparam int ADDR_W = $clog2(LEVELS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LEVELS - 1);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   logic [ADDR_W-1:0]   clear_cnt_ff;
   logic [ADDR_W-1:0]   clear_cnt_in;
   logic [LEVEL_W-1:0]  max_level_ff;

   logic                accept;
   logic                update_go;
   lane_op_type         req_op;
   lane_ctrl_type       ctrl;
   logic [LEVEL_W-1:0]  red_sel;
   logic [LEVEL_W-1:0]  green_sel;
   logic [LEVEL_W-1:0]  blue_sel;

   logic [COUNT_BITS-1:0] cnt_red;
   logic [COUNT_BITS-1:0] cnt_green;
   logic [COUNT_BITS-1:0] cnt_blue;
   lane_stat_type         stat_red;
   lane_stat_type         stat_green;
   lane_stat_type         stat_blue;

   // Level limit register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff <= MAX_LEVEL_RESET;
      end else if (csr_valid && csr_ready) begin
         max_level_ff <= csr_data;
      end
   end

   // Handshake
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign update_go = (state_ff == ST_UPDATE) && (!rsp_valid || !rsp_stall);

   // Decode the mode into a lane operation
   always_comb begin
      unique case (req_mode)
         MODE_COUNT: req_op = OP_COUNT;
         MODE_READ:  req_op = OP_READ;
         MODE_CLEAR: req_op = OP_CLEAR;
         default:    req_op = OP_NONE;
      endcase
   end

   // Route pixel levels in accumulate mode, the bin index otherwise
   always_comb begin
      if (req_mode == MODE_COUNT) begin
         red_sel   = req_red_level;
         green_sel = req_green_level;
         blue_sel  = req_blue_level;
      end else begin
         red_sel   = req_bin_index;
         green_sel = req_bin_index;
         blue_sel  = req_bin_index;
      end
   end

   always_comb begin
      ctrl.load   = accept;
      ctrl.update = update_go;
      ctrl.clear  = (state_ff == ST_CLEAR);
      ctrl.op     = req_op;
   end

   // Sequencer: clearing sweep, then one transaction at a time
   always_comb begin
      state_in     = state_ff;
      clear_cnt_in = clear_cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clear_cnt_in = clear_cnt_ff + ADDR_W'(1);
            if (clear_cnt_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (update_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   // Channel lanes
   rgbh_lane #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_lane_red (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .level      (red_sel),
      .max_level  (max_level_ff),
      .clear_addr (clear_cnt_ff),
      .count      (cnt_red),
      .stat       (stat_red)
   );

   rgbh_lane #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_lane_green (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .level      (green_sel),
      .max_level  (max_level_ff),
      .clear_addr (clear_cnt_ff),
      .count      (cnt_green),
      .stat       (stat_green)
   );

   rgbh_lane #(.LEVELS(LEVELS), .COUNT_BITS(COUNT_BITS)) u_lane_blue (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .level      (blue_sel),
      .max_level  (max_level_ff),
      .clear_addr (clear_cnt_ff),
      .count      (cnt_blue),
      .stat       (stat_blue)
   );

   // Merge the lanes into the response
   rgbh_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
      .clock              (clock),
      .reset              (reset),
      .load               (update_go),
      .lane_red           (cnt_red),
      .lane_green         (cnt_green),
      .lane_blue          (cnt_blue),
      .stat_red           (stat_red),
      .stat_green         (stat_green),
      .stat_blue          (stat_blue),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_red_count      (rsp_red_count),
      .rsp_green_count    (rsp_green_count),
      .rsp_blue_count     (rsp_blue_count),
      .rsp_level_rejected (rsp_level_rejected),
      .rsp_saturated      (rsp_saturated)
   );

   // Checks
   a_accept_to_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_UPDATE))
      else $error("accepted transaction did not enter update");

   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(update_go))
      else $error("response raised without an update");

   a_sweep_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clear_cnt_ff == LAST_ADDR) |=> (state_ff == ST_IDLE))
      else $error("clearing sweep did not end at the last bin");

   a_sat_no_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |->
         (rsp_red_count == '0 && rsp_green_count == '0 && rsp_blue_count == '0))
      else $error("saturated flag on a response that carries counts");

endmodule

// ===== hw/rtl/rgbh_lane.sv =====
// One color channel lane: bin memory with read-modify-write and limit check.
module rgbh_lane #(
   parameter int LEVELS     = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  rgbh_pkg::lane_ctrl_type       ctrl,
   input  logic [rgbh_pkg::LEVEL_W-1:0]  level,
   input  logic [rgbh_pkg::LEVEL_W-1:0]  max_level,
   input  logic [$clog2(LEVELS)-1:0]     clear_addr,
   output logic [COUNT_BITS-1:0]         count,
   output rgbh_pkg::lane_stat_type       stat
);
   import rgbh_pkg::*;

   localparam int ADDR_W = $clog2(LEVELS);
   localparam int EXT_W  = (ADDR_W > LEVEL_W) ? ADDR_W : LEVEL_W;

   logic [COUNT_BITS-1:0] bins_mem [LEVELS];

   logic [EXT_W-1:0]      level_ext;
   logic                  level_ok;
   logic [ADDR_W-1:0]     level_addr;

   lane_op_type           op_ff;
   logic                  ok_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [COUNT_BITS-1:0] rd_data_ff;

   logic                  full;
   logic                  wr_en;
   logic [ADDR_W-1:0]     wr_addr;
   logic [COUNT_BITS-1:0] wr_data;

   // Check the level against the limit and the bin count
   always_comb begin
      level_ext  = EXT_W'(level);
      level_ok   = (level <= max_level) &&
                   ({1'b0, level_ext} < (EXT_W + 1)'(LEVELS));
      level_addr = level_ext[ADDR_W-1:0];
   end

   // Capture the operation at transaction accept
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= OP_NONE;
         ok_ff <= 1'b0;
      end else if (ctrl.load) begin
         op_ff <= ctrl.op;
         ok_ff <= level_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         addr_ff <= level_addr;
      end
   end

   // Read the addressed bin
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rd_data_ff <= bins_mem[level_addr];
      end
   end

   assign full = (rd_data_ff == {COUNT_BITS{1'b1}});

   // Select the write: clearing sweep first, then the update
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = addr_ff;
      wr_data = rd_data_ff + COUNT_BITS'(1);
      priority if (ctrl.clear) begin
         wr_en   = 1'b1;
         wr_addr = clear_addr;
         wr_data = '0;
      end else if (ctrl.update && ok_ff) begin
         unique case (op_ff)
            OP_COUNT: begin
               wr_en = !full;
            end
            OP_CLEAR: begin
               wr_en   = 1'b1;
               wr_data = '0;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bins_mem[wr_addr] <= wr_data;
      end
   end

   // Report the count and the flags
   always_comb begin
      count = (ok_ff && (op_ff == OP_READ || op_ff == OP_CLEAR)) ? rd_data_ff : '0;
      stat.rejected  = (op_ff != OP_NONE) && !ok_ff;
      stat.saturated = (op_ff == OP_COUNT) && ok_ff && full;
   end

endmodule

// ===== hw/rtl/rgbh_merge.sv =====
// Merge stage: combines lane counts and flags into the registered response.
module rgbh_merge #(
   parameter int COUNT_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [COUNT_BITS-1:0]         lane_red,
   input  logic [COUNT_BITS-1:0]         lane_green,
   input  logic [COUNT_BITS-1:0]         lane_blue,
   input  rgbh_pkg::lane_stat_type       stat_red,
   input  rgbh_pkg::lane_stat_type       stat_green,
   input  rgbh_pkg::lane_stat_type       stat_blue,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [rgbh_pkg::FIELD_W-1:0]  rsp_red_count,
   output logic [rgbh_pkg::FIELD_W-1:0]  rsp_green_count,
   output logic [rgbh_pkg::FIELD_W-1:0]  rsp_blue_count,
   output logic                          rsp_level_rejected,
   output logic                          rsp_saturated
);
   import rgbh_pkg::*;

   logic [COUNT_BITS-1:0] lane_cnt [3];
   logic [FIELD_W-1:0]    field_cnt [3];

   logic                  valid_ff;
   logic                  valid_in;
   logic [FIELD_W-1:0]    red_ff;
   logic [FIELD_W-1:0]    green_ff;
   logic [FIELD_W-1:0]    blue_ff;
   logic                  rejected_ff;
   logic                  saturated_ff;

   assign lane_cnt[0] = lane_red;
   assign lane_cnt[1] = lane_green;
   assign lane_cnt[2] = lane_blue;

   // Clamp each lane count to the field width
   for (genvar g = 0; g < 3; g++) begin : g_clamp
      if (COUNT_BITS > FIELD_W) begin : g_wide
         assign field_cnt[g] = (|lane_cnt[g][COUNT_BITS-1:FIELD_W]) ?
                               {FIELD_W{1'b1}} : lane_cnt[g][FIELD_W-1:0];
      end else begin : g_narrow
         assign field_cnt[g] = FIELD_W'(lane_cnt[g]);
      end
   end

   // Hold the response until taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Combine the lanes
   always_ff @(posedge clock) begin
      if (load) begin
         red_ff       <= field_cnt[0];
         green_ff     <= field_cnt[1];
         blue_ff      <= field_cnt[2];
         rejected_ff  <= stat_red.rejected | stat_green.rejected | stat_blue.rejected;
         saturated_ff <= stat_red.saturated | stat_green.saturated | stat_blue.saturated;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_red_count      = red_ff;
   assign rsp_green_count    = green_ff;
   assign rsp_blue_count     = blue_ff;
   assign rsp_level_rejected = rejected_ff;
   assign rsp_saturated      = saturated_ff;

endmodule
